// ----- sv/dedup_refcount_slot_allocator_defines.svh -----
// Assertion helpers for the slot allocator. The enclosing module supplies
// signals named clk and rst_n.
`ifndef DEDUP_REFCOUNT_SLOT_ALLOCATOR_DEFINES_SVH
`define DEDUP_REFCOUNT_SLOT_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSRA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dsra_pkg.sv -----
package dsra_pkg;

  // Default sizes of the table.
  localparam int SLOTS_DEF    = 16;
  localparam int KEY_BITS_DEF = 64;
  localparam int REF_BITS_DEF = 16;

  // Fixed field widths of the ports.
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 64;
  localparam int SIDX_W   = 4;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_NEW      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

  // Flags of the search token that walks down the cell row.
  typedef struct packed {
    logic vld;    // a token occupies this stage
    logic acq;    // acquire search, else release
    logic hit;    // key found, or release target was occupied
    logic freed;  // release brought the count to zero
  } tok_ctl_t;

  // Broadcast table control from the sequencer to every cell.
  typedef struct packed {
    logic clear;    // drop every slot
    logic install;  // write a new slot at the broadcast index
  } cell_ctl_t;

endpackage

// ----- sv/dsra_cell.sv -----
module dsra_cell #(
  parameter int IDX      = 0,
  parameter int IW       = 4,
  parameter int KEY_BITS = 64,
  parameter int REF_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dsra_pkg::cell_ctl_t  ctl,
  input  logic [IW-1:0]        inst_idx,
  input  logic [KEY_BITS-1:0]  inst_key,
  input  dsra_pkg::tok_ctl_t   tok_i,
  input  logic [KEY_BITS-1:0]  tok_key_i,
  input  logic [IW-1:0]        tok_idx_i,
  output dsra_pkg::tok_ctl_t   tok_o,
  output logic [KEY_BITS-1:0]  tok_key_o,
  output logic [IW-1:0]        tok_idx_o
);
  import dsra_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                occ_r, occ_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [REF_BITS-1:0] refs_r, refs_nxt;
  logic [REF_BITS-1:0] refs_dec;
  tok_ctl_t            tok_nxt;
  logic [IW-1:0]       idx_nxt;

  assign refs_dec = (refs_r != '0) ? refs_r - REF_BITS'(1) : '0;

  always_comb begin
    occ_nxt  = occ_r;
    key_nxt  = key_r;
    refs_nxt = refs_r;
    tok_nxt  = tok_i;
    idx_nxt  = tok_idx_i;
    if (ctl.clear) begin
      occ_nxt = 1'b0;
    end else if (ctl.install && inst_idx == MY_IDX) begin
      occ_nxt  = 1'b1;
      key_nxt  = inst_key;
      refs_nxt = REF_BITS'(1);
    end else if (tok_i.vld) begin
      if (tok_i.acq) begin
        if (occ_r && key_r == tok_key_i && !tok_i.hit) begin
          tok_nxt.hit = 1'b1;
          idx_nxt     = MY_IDX;
          if (refs_r != '1) begin
            refs_nxt = refs_r + REF_BITS'(1);
          end
        end
      end else if (tok_idx_i == MY_IDX && occ_r) begin
        tok_nxt.hit = 1'b1;
        refs_nxt    = refs_dec;
        if (refs_dec == '0) begin
          occ_nxt       = 1'b0;
          tok_nxt.freed = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      tok_o <= '0;
    end else begin
      occ_r <= occ_nxt;
      tok_o <= tok_nxt;
    end
  end

  // The key only moves along with a token, so the tail keeps the last
  // searched key until the sequencer has installed it.
  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    refs_r    <= refs_nxt;
    tok_idx_o <= idx_nxt;
    if (tok_i.vld) begin
      tok_key_o <= tok_key_i;
    end
  end

endmodule

// ----- sv/dedup_refcount_slot_allocator.sv -----
// Channel | Direction | Transfer condition    | Payload
// in_     | input     | in_valid & in_ready   | command, state_key, slot_index
// out_    | output    | out_valid & out_ready | slot, status, dirty_valid/first/last
// cfg_    | input     | cfg_valid & cfg_ready | slot_limit
//
// Flow: an acquire or in-range release sends a search token through each cell
// of the row, then writes the result register (via a pop state when a slot is
// taken from the free stack). A clear or an out-of-range release writes the
// result register directly; an unused command is consumed without a result.
// Reset: synchronous, active low; the table starts empty with slot_limit 16.
// Stalls: the next item is taken while a result waits on the output register;
// it finishes only when that register has been emptied.
`include "dedup_refcount_slot_allocator_defines.svh"

module dedup_refcount_slot_allocator #(
  parameter int SLOTS    = dsra_pkg::SLOTS_DEF,
  parameter int KEY_BITS = dsra_pkg::KEY_BITS_DEF,
  parameter int REF_BITS = dsra_pkg::REF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dsra_pkg::CMD_W-1:0]    in_command,
  input  logic [dsra_pkg::KEY_W-1:0]    in_state_key,
  input  logic [dsra_pkg::SIDX_W-1:0]   in_slot_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dsra_pkg::SIDX_W-1:0]   out_slot,
  output logic [dsra_pkg::STATUS_W-1:0] out_status,
  output logic                          out_dirty_valid,
  output logic [dsra_pkg::SIDX_W-1:0]   out_dirty_first,
  output logic [dsra_pkg::SIDX_W-1:0]   out_dirty_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dsra_pkg::LIMIT_W-1:0]  cfg_slot_limit
);
  import dsra_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [LIMIT_W-1:0]  limit_r, limit_nxt;
  logic [CW-1:0]       free_count_r, free_count_nxt;
  logic [CW-1:0]       next_fresh_r, next_fresh_nxt;
  logic                dirty_vld_r, dirty_vld_nxt;
  logic [IW-1:0]       dirty_lo_r, dirty_lo_nxt;
  logic [IW-1:0]       dirty_hi_r, dirty_hi_nxt;
  logic [IW-1:0]       res_slot_r, res_slot_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SIDX_W-1:0]   out_slot_r, out_slot_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_dv_r, out_dv_nxt;
  logic [SIDX_W-1:0]   out_df_r, out_df_nxt;
  logic [SIDX_W-1:0]   out_dl_r, out_dl_nxt;

  // The free stack is a small memory with a registered read port. The read
  // address always points at the top entry, so the popped slot is ready in the
  // pop state that follows the search.
  logic [IW-1:0] free_mem [SLOTS];
  logic [IW-1:0] pop_data_r;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [IW-1:0] mem_wd;

  // Cell row. Stage 0 is the launch point driven by the sequencer; stage
  // SLOTS is the tail that the sequencer watches for the finished token.
  tok_ctl_t            tok   [SLOTS+1];
  logic [KEY_BITS-1:0] tkey  [SLOTS+1];
  logic [IW-1:0]       tidx  [SLOTS+1];
  logic [SLOTS-1:0]    tok_vld_vec;
  cell_ctl_t           ctl;
  logic [IW-1:0]       inst_idx;

  logic in_acc;
  logic cfg_acc;
  logic launch;
  logic rel_ok;
  logic fresh_ok;

  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign rel_ok    = 32'(in_slot_index) < SLOTS;
  assign fresh_ok  = (32'(next_fresh_r) < 32'(limit_r)) && (next_fresh_r < SLOTS_C);
  assign rd_addr   = IW'(free_count_r - CW'(1));

  assign out_valid       = out_valid_r;
  assign out_slot        = out_slot_r;
  assign out_status      = out_status_r;
  assign out_dirty_valid = out_dv_r;
  assign out_dirty_first = out_df_r;
  assign out_dirty_last  = out_dl_r;

  // Launch a token into the first cell when an acquire or an in-range release
  // is accepted. The key is trimmed to the stored width here.
  always_comb begin
    tok[0]     = '0;
    tok[0].vld = launch;
    tok[0].acq = (in_command == CMD_ACQUIRE);
  end
  assign tkey[0] = in_state_key[KEY_BITS-1:0];
  assign tidx[0] = IW'(in_slot_index);

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    dsra_cell #(
      .IDX      (g),
      .IW       (IW),
      .KEY_BITS (KEY_BITS),
      .REF_BITS (REF_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .inst_idx  (inst_idx),
      .inst_key  (tkey[SLOTS]),
      .tok_i     (tok[g]),
      .tok_key_i (tkey[g]),
      .tok_idx_i (tidx[g]),
      .tok_o     (tok[g+1]),
      .tok_key_o (tkey[g+1]),
      .tok_idx_o (tidx[g+1])
    );
    assign tok_vld_vec[g] = tok[g+1].vld;
  end

  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    free_count_nxt = free_count_r;
    next_fresh_nxt = next_fresh_r;
    dirty_vld_nxt  = dirty_vld_r;
    dirty_lo_nxt   = dirty_lo_r;
    dirty_hi_nxt   = dirty_hi_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_dv_nxt     = out_dv_r;
    out_df_nxt     = out_df_r;
    out_dl_nxt     = out_dl_r;
    ctl            = '0;
    inst_idx       = '0;
    launch         = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = free_count_r[IW-1:0];
    mem_wd         = tidx[SLOTS];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (cfg_acc) begin
          // A new limit empties the whole table.
          limit_nxt      = cfg_slot_limit;
          ctl.clear      = 1'b1;
          free_count_nxt = '0;
          next_fresh_nxt = '0;
          dirty_vld_nxt  = 1'b0;
          dirty_lo_nxt   = '0;
          dirty_hi_nxt   = '0;
        end else if (in_acc) begin
          unique case (in_command)
            CMD_ACQUIRE: begin
              launch    = 1'b1;
              state_nxt = S_SCAN;
            end
            CMD_RELEASE: begin
              res_slot_nxt = '0;
              if (rel_ok) begin
                launch    = 1'b1;
                state_nxt = S_SCAN;
              end else begin
                res_status_nxt = ST_UNKNOWN;
                state_nxt      = S_EMIT;
              end
            end
            CMD_CLEAR: begin
              dirty_vld_nxt  = 1'b0;
              dirty_lo_nxt   = '0;
              dirty_hi_nxt   = '0;
              res_slot_nxt   = '0;
              res_status_nxt = ST_CLEARED;
              state_nxt      = S_EMIT;
            end
            default: begin
              // Unused command: consumed without a result.
            end
          endcase
        end
      end

      S_SCAN: begin
        if (tok[SLOTS].vld) begin
          res_slot_nxt = '0;
          state_nxt    = S_EMIT;
          if (tok[SLOTS].acq) begin
            if (tok[SLOTS].hit) begin
              res_slot_nxt   = tidx[SLOTS];
              res_status_nxt = ST_HIT;
            end else if (free_count_r != '0) begin
              state_nxt = S_POP;
            end else if (fresh_ok) begin
              ctl.install    = 1'b1;
              inst_idx       = next_fresh_r[IW-1:0];
              next_fresh_nxt = next_fresh_r + CW'(1);
              res_slot_nxt   = next_fresh_r[IW-1:0];
              res_status_nxt = ST_NEW;
            end else begin
              res_status_nxt = ST_FULL;
            end
          end else if (!tok[SLOTS].hit) begin
            res_status_nxt = ST_UNKNOWN;
          end else begin
            if (tok[SLOTS].freed && free_count_r < SLOTS_C) begin
              mem_we         = 1'b1;
              free_count_nxt = free_count_r + CW'(1);
            end
            res_status_nxt = ST_RELEASED;
          end
        end
      end

      S_POP: begin
        ctl.install    = 1'b1;
        inst_idx       = pop_data_r;
        free_count_nxt = free_count_r - CW'(1);
        res_slot_nxt   = pop_data_r;
        res_status_nxt = ST_NEW;
        state_nxt      = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = SIDX_W'(res_slot_r);
          out_status_nxt = res_status_r;
          out_dv_nxt     = dirty_vld_r;
          out_df_nxt     = SIDX_W'(dirty_lo_r);
          out_dl_nxt     = SIDX_W'(dirty_hi_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A newly written slot widens the dirty range. While the range is empty
    // both bounds sit at zero, so the first write sets them to the slot.
    if (ctl.install) begin
      dirty_vld_nxt = 1'b1;
      if (!dirty_vld_r || inst_idx < dirty_lo_r) begin
        dirty_lo_nxt = inst_idx;
      end
      if (inst_idx > dirty_hi_r) begin
        dirty_hi_nxt = inst_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      limit_r      <= LIMIT_RESET;
      free_count_r <= '0;
      next_fresh_r <= '0;
      dirty_vld_r  <= 1'b0;
      dirty_lo_r   <= '0;
      dirty_hi_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      limit_r      <= limit_nxt;
      free_count_r <= free_count_nxt;
      next_fresh_r <= next_fresh_nxt;
      dirty_vld_r  <= dirty_vld_nxt;
      dirty_lo_r   <= dirty_lo_nxt;
      dirty_hi_r   <= dirty_hi_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_dv_r     <= out_dv_nxt;
    out_df_r     <= out_df_nxt;
    out_dl_r     <= out_dl_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      free_mem[mem_wa] <= mem_wd;
    end
    pop_data_r <= free_mem[rd_addr];
  end

  // Only one search runs through the row at a time.
  `DSRA_ASSERT_NOW(a_one_token, 1'b1, $countones(tok_vld_vec) <= 1,
    "more than one search token in the cell row")
  // A finished token can only arrive while the sequencer waits for it.
  `DSRA_ASSERT_NOW(a_tail_in_scan, tok[SLOTS].vld, state_r == S_SCAN,
    "search token left the row outside the scan state")
  // A pop is only issued from a non-empty free stack.
  `DSRA_ASSERT_NOW(a_pop_nonempty, state_r == S_POP, free_count_r != '0,
    "pop from an empty free stack")
  // Writing a slot always leaves a valid dirty range behind.
  `DSRA_ASSERT_NEXT(a_install_dirty, ctl.install, dirty_vld_r && dirty_lo_r <= dirty_hi_r,
    "dirty range not valid after a slot was written")

endmodule
